// ===== rtl/core/deq_pkg.sv =====
// Shared sizes, operation and status codes, and controller/datapath link types
// for the double-ended queue core. Depends on nothing.
package deq_pkg;

    localparam int DEPTH     = 32;
    localparam int DATA_BITS = 8;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int KIND_W  = 2;
    localparam int VAL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 6;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_kind OP_PUSH_FRONT = 2'd0;
    localparam t_kind OP_PUSH_REAR  = 2'd1;
    localparam t_kind OP_POP_FRONT  = 2'd2;
    localparam t_kind OP_POP_REAR   = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_mem;
    } t_dp_cmd;

    typedef struct packed {
        logic needs_read;
    } t_dp_stat;

endpackage

// ===== rtl/core/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Controller: input/output handshake, output valid flag and the wait state
// for a RAM read. Depends on deq_pkg.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.needs_read) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if ((accept && !i_stat.needs_read) || (r_state == S_READ)) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.load_mem = (r_state == S_READ);

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("read result would overwrite a pending word");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_state == S_IDLE))
        else $error("read result not presented");

    a_accept_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_stat.needs_read) |=> (r_state == S_READ && !r_out_valid))
        else $error("pop read not scheduled");

endmodule

// ===== rtl/core/deq_datapath.sv =====
// Datapath: head pointer, entry count, circular-buffer addressing, storage RAM
// and the result register. Depends on deq_pkg and deq_ram.
module deq_datapath
    import deq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  t_kind                i_kind,
    input  logic [VAL_W-1:0]     i_push_value,
    output logic [VAL_W-1:0]     o_pop_value,
    output t_status              o_status,
    output logic [OCC_W-1:0]     o_occupancy
);

    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [VAL_W-1:0]     r_pop_value;
    t_status              r_status, n_status;
    logic [OCC_W-1:0]     r_occ;

    logic                 full, empty;
    logic [IDX_W-1:0]     head_m1, head_p1, tail_ix, last_ix;
    logic [SUM_W-1:0]     tail_sum, last_sum;
    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [DATA_BITS-1:0] wdata, rdata;

    assign full  = (r_count == DEPTH_C);
    assign empty = (r_count == '0);

    assign head_m1  = (r_head == '0) ? LAST_IX : r_head - 1'b1;
    assign head_p1  = (r_head == LAST_IX) ? '0 : r_head + 1'b1;
    assign tail_sum = {1'b0, r_head} + SUM_W'(r_count);
    assign last_sum = tail_sum - 1'b1;
    assign tail_ix  = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    assign last_ix  = (last_sum >= DEPTH_S) ? IDX_W'(last_sum - DEPTH_S) : IDX_W'(last_sum);

    assign wdata = DATA_BITS'(i_push_value);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        waddr    = tail_ix;
        raddr    = r_head;
        o_stat.needs_read = 1'b0;
        case (i_kind)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    waddr   = head_m1;
                    n_head  = head_m1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_REAR: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    o_stat.needs_read = 1'b1;
                    n_head  = head_p1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    o_stat.needs_read = 1'b1;
                    raddr   = last_ix;
                    n_count = r_count - 1'b1;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.accept),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status    <= n_status;
            r_occ       <= OCC_W'(n_count);
            r_pop_value <= '0;
        end else if (i_cmd.load_mem) begin
            r_pop_value <= VAL_W'(rdata);
        end
    end

    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= DEPTH_C) && (SUM_W'(r_head) < DEPTH_S))
        else $error("queue pointer or count out of range");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.accept) |-> ($stable(r_count) && $stable(r_head)))
        else $error("queue state moved without an accepted word");

endmodule

// ===== rtl/core/double_ended_queue_core.sv =====
// Double-ended queue of DATA_BITS-wide characters in a DEPTH-entry circular
// buffer; each input word is one push or pop at either end and yields one result
// word with the popped value, a status code and the occupancy afterwards. A push
// or a refused operation has its result registered on acceptance; a successful pop
// first waits in a read state, as the storage RAM has a registered read port. One word is in work
// at a time; the next is accepted once its result has been taken or in the
// cycle the held result leaves. Depends on deq_pkg, deq_ctrl, deq_datapath.
module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_kind            i_kind,
    input  logic [VAL_W-1:0] i_push_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAL_W-1:0] o_pop_value,
    output t_status          o_status,
    output logic [OCC_W-1:0] o_occupancy
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    deq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

// ===== dv/tb_double_ended_queue_core.sv =====
`timescale 1ns / 100ps
// Testbench for double_ended_queue_core: a directed opener and biased random fill/drain runs,
// with bursty input, patterned output stall and an in-order deque model checking each result word.
// Depends on deq_pkg and the double_ended_queue_core RTL.
module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam int TOTAL_OPS   = 550;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        t_kind            kind;
        logic [VAL_W-1:0] value;
    } t_op;

    typedef struct packed {
        logic [VAL_W-1:0] pop_value;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_deq_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    t_kind            i_kind       = OP_POP_FRONT;
    logic [VAL_W-1:0] i_push_value = '0;
    logic             i_out_stall  = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [VAL_W-1:0] o_pop_value;
    t_status          o_status;
    logic [OCC_W-1:0] o_occupancy;

    t_op         op_backlog[$];
    t_deq_result expected_results[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 8;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          stall_mode  = 0;

    logic [DATA_BITS-1:0] shadow_store[DEPTH];
    int                   shadow_head;
    int                   shadow_count;

    double_ended_queue_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_deq_result deque_apply(t_kind kind, logic [VAL_W-1:0] value);
        t_deq_result res;
        int          slot;
        res = '0;
        res.status = ST_OK;
        if (kind == OP_PUSH_FRONT || kind == OP_PUSH_REAR) begin
            if (shadow_count >= DEPTH) begin
                res.status = ST_FULL;
            end else if (kind == OP_PUSH_FRONT) begin
                shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                shadow_store[shadow_head] = value[DATA_BITS-1:0];
                shadow_count++;
            end else begin
                slot = (shadow_head + shadow_count) % DEPTH;
                shadow_store[slot] = value[DATA_BITS-1:0];
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else if (kind == OP_POP_FRONT) begin
                res.pop_value = VAL_W'(shadow_store[shadow_head]);
                shadow_head = (shadow_head + 1) % DEPTH;
                shadow_count--;
            end else begin
                slot = (shadow_head + shadow_count - 1) % DEPTH;
                res.pop_value = VAL_W'(shadow_store[slot]);
                shadow_count--;
            end
        end
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    task automatic queue_op(t_kind kind, logic [VAL_W-1:0] value);
        t_op op;
        op.kind  = kind;
        op.value = value;
        op_backlog.push_back(op);
    endtask

    // driver: bursts of words separated by random gaps
    always @(posedge i_clk) begin
        t_op op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(deque_apply(i_kind, i_push_value));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0 || op_backlog.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    op = op_backlog.pop_front();
                    i_kind       <= op.kind;
                    i_push_value <= op.value;
                    i_in_valid   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall: segments of no stall, light, heavy and near-continuous stall
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 7) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 4) != 0);
            end
        endcase
    end

    // monitor
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word pop_value %h status %0d occupancy %0d",
                         $time, o_pop_value, o_status, o_occupancy);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_pop_value !== want.pop_value) begin
                    $display("%0t: pop_value expected %h actual %h",
                             $time, want.pop_value, o_pop_value);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, o_occupancy);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int    mode;
        int    run;
        int    roll;
        bit    is_push;
        t_kind kind;
        shadow_head  = 0;
        shadow_count = 0;

        queue_op(OP_POP_FRONT,  8'hFF);
        queue_op(OP_POP_REAR,   8'hFF);
        queue_op(OP_PUSH_FRONT, 8'h00);
        queue_op(OP_PUSH_REAR,  8'hFF);
        queue_op(OP_PUSH_FRONT, 8'h80);
        queue_op(OP_PUSH_REAR,  8'h01);
        queue_op(OP_POP_FRONT,  8'h5A);
        queue_op(OP_POP_REAR,   8'h00);
        queue_op(OP_POP_REAR,   8'hFF);
        queue_op(OP_POP_FRONT,  8'h00);
        queue_op(OP_POP_FRONT,  8'h00);
        queue_op(OP_PUSH_REAR,  8'h55);
        queue_op(OP_PUSH_REAR,  8'hAA);
        queue_op(OP_PUSH_FRONT, 8'h7F);
        queue_op(OP_POP_REAR,   8'h00);
        queue_op(OP_POP_FRONT,  8'h00);
        queue_op(OP_POP_FRONT,  8'h00);
        queue_op(OP_POP_REAR,   8'h00);

        // fill-biased, drain-biased and balanced runs drive the queue to both ends and wrap
        while (op_backlog.size() < TOTAL_OPS) begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 48);
            repeat (run) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0: begin
                        is_push = (roll < 88);
                    end
                    1: begin
                        is_push = (roll < 12);
                    end
                    default: begin
                        is_push = (roll < 50);
                    end
                endcase
                if (is_push) begin
                    kind = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                end else begin
                    kind = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
                end
                queue_op(kind, VAL_W'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (op_backlog.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
